### hdl/dtoi_pkg.sv
// Shared types and constants for the decimal text to integer converter.
// No dependencies; imported by decimal_text_to_integer.
`default_nettype none

package dtoi_pkg;

	// widths of the stream fields
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned VALUE_W = 64;
	localparam int unsigned DIGIT_W = 4;
	localparam int unsigned CFG_IDX_W = 2;

	// register indexes on the write port
	localparam logic [CFG_IDX_W-1:0] REG_SEPARATOR   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SIGNED_MODE = 2'd1;

	// character codes
	localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
	localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
	localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
	localparam logic [BYTE_W-1:0] SEP_NONE = 8'h00;

	// parse phase of the current field
	typedef enum logic [2:0] {
		PH_LEADING = 3'd0,
		PH_BODY    = 3'd1,
		PH_FAILED  = 3'd2
	} phase_t;

	// byte class flags, computed when a beat enters the input register
	typedef struct packed {
		logic is_space;
		logic is_digit;
		logic is_plus;
		logic is_minus; // minus sign and signed mode enabled
		logic is_sep;
	} byte_class_t;

endpackage

`default_nettype wire

### hdl/decimal_text_to_integer.sv
// Streaming decimal text to 64-bit integer converter, top level.
// Depends on dtoi_pkg (types, character constants).
//
// Usage:
//   Slave stream s_*: one text byte per beat in s_tdata, s_tlast on the
//   final byte of a field. Master stream m_*: one beat per field, with the
//   value in m_tdata and the success flag in m_tuser. Value is 0 on failure.
//   Config port: cfg_we writes cfg_data to register cfg_index
//   (0 separator byte, 1 signed mode); other indexes are ignored.
// Result path: the last byte of a field passes through the input register,
//   then the result register, which drives the result beat.
// Throughput: one byte per cycle while no final byte is held (see Stall),
//   bounded by the parse update, a saturating 64-bit multiply-by-ten-and-add.
// Reset: arst_n clears both streams, the parse state, and restores the
//   separator to none and signed mode to on.
// Stall: while a result waits on m_tready, non-final bytes keep flowing;
//   a final byte is held in the input register until the result register
//   frees up, and s_tready then drops until it moves on.
`default_nettype none

module decimal_text_to_integer (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// slave stream
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	input  wire logic [dtoi_pkg::BYTE_W-1:0]    s_tdata,   // [7:0] text_byte
	input  wire logic                           s_tlast,   // is_last
	// master stream
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	output logic [dtoi_pkg::VALUE_W-1:0]        m_tdata,   // [63:0] parsed_value
	output logic                                m_tuser,   // parse_ok
	// configuration write port
	input  wire logic                           cfg_we,
	input  wire logic [dtoi_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [dtoi_pkg::BYTE_W-1:0]    cfg_data
);
	import dtoi_pkg::*;

	// configuration registers
	logic [BYTE_W-1:0] separator_q;
	logic              signed_mode_q;

	// input register
	logic               valid_s1;
	logic               last_s1;
	byte_class_t        class_s1;
	logic [DIGIT_W-1:0] digit_s1;

	// parse state
	phase_t              phase_q, phase_d;
	logic [VALUE_W-1:0]  mag_q, mag_d;
	logic                neg_q, neg_d;
	logic                pend_q, pend_d;
	logic                acc_en;

	// result register
	logic               out_valid_q;
	logic [VALUE_W-1:0] out_mag_q;
	logic               out_neg_q;
	logic               out_ok_q;

	byte_class_t        class_in;
	logic               advance;
	logic [VALUE_W+3:0] acc_sum;
	logic [VALUE_W-1:0] acc_val;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			separator_q   <= SEP_NONE;
			signed_mode_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SEPARATOR:   separator_q   <= cfg_data;
				REG_SIGNED_MODE: signed_mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// classify the incoming byte
	always_comb begin
		class_in.is_space = (s_tdata == CH_SPACE) || (s_tdata == CH_TAB) ||
			(s_tdata == CH_LF) || (s_tdata == CH_CR);
		class_in.is_digit = (s_tdata >= CH_ZERO) && (s_tdata <= CH_NINE);
		class_in.is_plus  = (s_tdata == CH_PLUS);
		class_in.is_minus = (s_tdata == CH_MINUS) && signed_mode_q;
		class_in.is_sep   = (separator_q != SEP_NONE) && (s_tdata == separator_q);
	end

	// a final byte moves on only when the result register is free
	assign advance  = valid_s1 && (!last_s1 || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			last_s1  <= s_tlast;
			class_s1 <= class_in;
			digit_s1 <= s_tdata[DIGIT_W-1:0];
		end
	end

	// mag*10 + digit, saturating at all ones
	assign acc_sum = {1'b0, mag_q, 3'b000} + {3'b000, mag_q, 1'b0} +
		{{(VALUE_W){1'b0}}, digit_s1};
	assign acc_val = (acc_sum[VALUE_W+3:VALUE_W] != 4'd0) ? {VALUE_W{1'b1}} :
		acc_sum[VALUE_W-1:0];

	// next phase
	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			PH_LEADING: begin
				if (class_s1.is_space)
					phase_d = PH_LEADING;
				else if (class_s1.is_digit || class_s1.is_plus || class_s1.is_minus)
					phase_d = PH_BODY;
				else
					phase_d = PH_FAILED;
			end
			PH_BODY: begin
				if (!pend_q) begin
					if (!class_s1.is_space)
						phase_d = PH_FAILED;
				end else if (!class_s1.is_sep && !class_s1.is_space &&
						!class_s1.is_digit) begin
					phase_d = PH_FAILED;
				end
			end
			PH_FAILED: phase_d = PH_FAILED;
			default:   phase_d = PH_FAILED;
		endcase
	end

	// magnitude, sign and trailing-space tracking
	always_comb begin
		acc_en = 1'b0;
		neg_d  = neg_q;
		pend_d = pend_q;
		case (phase_q)
			PH_LEADING: begin
				if (!class_s1.is_space) begin
					acc_en = class_s1.is_digit;
					if (!class_s1.is_digit && !class_s1.is_plus && class_s1.is_minus)
						neg_d = 1'b1;
				end
			end
			PH_BODY: begin
				if (pend_q && !class_s1.is_sep) begin
					if (class_s1.is_space)
						pend_d = 1'b0;
					else
						acc_en = class_s1.is_digit;
				end
			end
			default: ;
		endcase
		mag_d = acc_en ? acc_val : mag_q;
	end

	// parse state; cleared at the end of each field
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LEADING;
			mag_q   <= '0;
			neg_q   <= 1'b0;
			pend_q  <= 1'b1;
		end else if (advance) begin
			if (last_s1) begin
				phase_q <= PH_LEADING;
				mag_q   <= '0;
				neg_q   <= 1'b0;
				pend_q  <= 1'b1;
			end else begin
				phase_q <= phase_d;
				mag_q   <= mag_d;
				neg_q   <= neg_d;
				pend_q  <= pend_d;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			out_ok_q  <= (phase_d == PH_BODY);
			out_mag_q <= (phase_d == PH_BODY) ? mag_d : '0;
			out_neg_q <= (phase_d == PH_BODY) && neg_d;
		end
	end

	// two's complement on the way out for negative values
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_neg_q ? ({VALUE_W{1'b0}} - out_mag_q) : out_mag_q;
	assign m_tuser  = out_ok_q;

endmodule

`default_nettype wire
